/* sv/bmirq_pkg.sv */
// ----------------------------------------------------------------------------
// bmirq_pkg
// Types, access kinds, command codes and mirroring table for the bank mapper.
// ----------------------------------------------------------------------------
package bmirq_pkg;

    localparam int PRG_OFF_W   = 13;   // 8 KiB program bank
    localparam int CHR_OFF_W   = 10;   // 1 KiB character bank
    localparam int BANK_W      = 8;
    localparam int ROM_ADDR_W  = BANK_W + PRG_OFF_W;
    localparam int CHR_ADDR_W  = BANK_W + CHR_OFF_W;
    localparam int CHR_BANKS   = 8;
    localparam int PRG_BANKS   = 3;

    typedef enum logic [1:0] {
        MODE_CPU_WRITE = 2'd0,
        MODE_CPU_READ  = 2'd1,
        MODE_PPU_FETCH = 2'd2,
        MODE_TICK      = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        CMD_CHR0   = 4'h0,
        CMD_CHR1   = 4'h1,
        CMD_CHR2   = 4'h2,
        CMD_CHR3   = 4'h3,
        CMD_CHR4   = 4'h4,
        CMD_CHR5   = 4'h5,
        CMD_CHR6   = 4'h6,
        CMD_CHR7   = 4'h7,
        CMD_WINDOW = 4'h8,
        CMD_PRG0   = 4'h9,
        CMD_PRG1   = 4'hA,
        CMD_PRG2   = 4'hB,
        CMD_MIRROR = 4'hC,
        CMD_IRQ_EN = 4'hD,
        CMD_IRQ_LO = 4'hE,
        CMD_IRQ_HI = 4'hF
    } cmd_t;

    typedef enum logic [0:0] {
        CFG_PRG_MASK = 1'b0,
        CFG_CHR_MASK = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        MIRROR_VERTICAL   = 2'd0,
        MIRROR_HORIZONTAL = 2'd1,
        MIRROR_SINGLE_LO  = 2'd2,
        MIRROR_SINGLE_HI  = 2'd3
    } mirror_t;

    localparam logic [15:0] IRQ_RELOAD   = 16'hFFFF;
    localparam logic [7:0]  WIN_ROM_BIT  = 8'h40;
    localparam logic [7:0]  WIN_RAM_BIT  = 8'h80;

    typedef struct packed {
        logic [ROM_ADDR_W-1:0] rom_address;
        logic [CHR_ADDR_W-1:0] chr_address;
        logic                  wram_hit;
        logic                  nametable_page;
        logic                  irq;
    } result_t;

    function automatic logic nt_page(input mirror_t m, input logic [1:0] quad);
        logic p;
        p = 1'b0;
        unique case (m)
            MIRROR_VERTICAL:   p = quad[0];
            MIRROR_HORIZONTAL: p = quad[1];
            MIRROR_SINGLE_LO:  p = 1'b0;
            MIRROR_SINGLE_HI:  p = 1'b1;
            default:           p = 1'b0;
        endcase
        return p;
    endfunction

endpackage

/* sv/bank_mapper_with_irq_counter_unit.sv */
// ----------------------------------------------------------------------------
// bank_mapper_with_irq_counter_unit
// Cartridge bank mapper with command latch, bank registers and IRQ counter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one bus item: CPU write, CPU
//   read, PPU fetch or timer tick (mode, address, data, tick_count).
//   Output channel (out_valid/out_ready) returns exactly one result per item:
//   translated program ROM address, character address, work RAM hit,
//   nametable page and IRQ pulse.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the
//   program and character bank masks; it is always ready. The user must write
//   it only while no item is in flight; the block does not enforce this.
//   The input register is loaded at acceptance and the result register after
//   it, once the result stage can advance; the bank lookup and state update
//   run between the two.
//   Throughput: one item per cycle while out_ready is high; both stages
//   advance together, so bank and IRQ counter updates follow item order.
//   A stalled receiver holds the result register; the input register still
//   takes one further item, after which in_ready drops until the result
//   moves on.
//   Reset clears all bank registers, the latch and the counter, selects work
//   RAM in the 6000 window, sets both masks to 255 and empties both stages.
// ----------------------------------------------------------------------------
module bank_mapper_with_irq_counter_unit
    import bmirq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            mode,
    input  logic [15:0]           address,
    input  logic [7:0]            data,
    input  logic [15:0]           tick_count,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ROM_ADDR_W-1:0] rom_address,
    output logic [CHR_ADDR_W-1:0] chr_address,
    output logic                  wram_hit,
    output logic                  nametable_page,
    output logic                  irq,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [7:0]            cfg_data
);

    // pipeline
    logic        in_vld_reg;
    mode_t       mode_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;
    logic [15:0] ticks_reg;
    logic        out_vld_reg;
    result_t     res_reg;
    result_t     res_next;
    logic        advance;

    // mapper state
    logic [BANK_W-1:0] prg_mask_reg;
    logic [BANK_W-1:0] chr_mask_reg;
    cmd_t              cmd_reg,      cmd_next;
    logic [BANK_W-1:0] chr_bank_reg  [CHR_BANKS];
    logic [BANK_W-1:0] chr_bank_next [CHR_BANKS];
    logic [BANK_W-1:0] prg_bank_reg  [PRG_BANKS];
    logic [BANK_W-1:0] prg_bank_next [PRG_BANKS];
    logic              wram_sel_reg,  wram_sel_next;
    logic [BANK_W-1:0] win_bank_reg,  win_bank_next;
    mirror_t           mirror_reg,    mirror_next;
    logic              irq_en_reg,    irq_en_next;
    logic [15:0]       irq_cnt_reg,   irq_cnt_next;

    logic [PRG_OFF_W-1:0] prg_off;
    logic [1:0]           slot;
    logic [BANK_W-1:0]    slot_bank;
    logic                 is_cpu;

    assign advance   = out_ready || !out_vld_reg;
    assign in_ready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid      = out_vld_reg;
    assign rom_address    = res_reg.rom_address;
    assign chr_address    = res_reg.chr_address;
    assign wram_hit       = res_reg.wram_hit;
    assign nametable_page = res_reg.nametable_page;
    assign irq            = res_reg.irq;

    assign prg_off = addr_reg[PRG_OFF_W-1:0];
    assign slot    = addr_reg[14:13];
    assign is_cpu  = (mode_reg == MODE_CPU_WRITE) || (mode_reg == MODE_CPU_READ);

    always_comb
    begin
        unique case (slot)
            2'd0:    slot_bank = prg_bank_reg[0];
            2'd1:    slot_bank = prg_bank_reg[1];
            2'd2:    slot_bank = prg_bank_reg[2];
            default: slot_bank = prg_mask_reg;     // fixed last bank
        endcase
    end

    // result
    always_comb
    begin
        res_next = '0;
        if (is_cpu)
        begin
            if (addr_reg[15])
                res_next.rom_address = {slot_bank, prg_off};
            else if (addr_reg[14:13] == 2'b11)
            begin
                if (wram_sel_reg)
                    res_next.wram_hit = 1'b1;
                else
                    res_next.rom_address = {win_bank_reg, prg_off};
            end
        end
        else if (mode_reg == MODE_PPU_FETCH)
        begin
            if (addr_reg[15:13] == 3'b000)
                res_next.chr_address = {chr_bank_reg[addr_reg[12:10]],
                                        addr_reg[CHR_OFF_W-1:0]};
            else if (addr_reg[15:12] == 4'h2)
                res_next.nametable_page = nt_page(mirror_reg, addr_reg[11:10]);
        end
        else
        begin
            res_next.irq = irq_en_reg && (irq_cnt_reg <= ticks_reg);
        end
    end

    // state update
    always_comb
    begin
        cmd_next      = cmd_reg;
        chr_bank_next = chr_bank_reg;
        prg_bank_next = prg_bank_reg;
        wram_sel_next = wram_sel_reg;
        win_bank_next = win_bank_reg;
        mirror_next   = mirror_reg;
        irq_en_next   = irq_en_reg;
        irq_cnt_next  = irq_cnt_reg;

        if (mode_reg == MODE_CPU_WRITE && addr_reg[15:14] == 2'b10)
        begin
            if (!addr_reg[13])
                cmd_next = cmd_t'(data_reg[3:0]);
            else
            begin
                unique case (cmd_reg)
                    CMD_CHR0, CMD_CHR1, CMD_CHR2, CMD_CHR3,
                    CMD_CHR4, CMD_CHR5, CMD_CHR6, CMD_CHR7:
                        chr_bank_next[cmd_reg[2:0]] = data_reg & chr_mask_reg;
                    CMD_WINDOW:
                    begin
                        if ((data_reg & WIN_ROM_BIT) == '0)
                        begin
                            wram_sel_next = 1'b0;
                            win_bank_next = data_reg & prg_mask_reg;
                        end
                        else if ((data_reg & WIN_RAM_BIT) != '0)
                            wram_sel_next = 1'b1;
                    end
                    CMD_PRG0:   prg_bank_next[0] = data_reg & prg_mask_reg;
                    CMD_PRG1:   prg_bank_next[1] = data_reg & prg_mask_reg;
                    CMD_PRG2:   prg_bank_next[2] = data_reg & prg_mask_reg;
                    CMD_MIRROR: mirror_next = mirror_t'(data_reg[1:0]);
                    CMD_IRQ_EN: irq_en_next = (data_reg != '0);
                    CMD_IRQ_LO: irq_cnt_next = {irq_cnt_reg[15:8], data_reg};
                    CMD_IRQ_HI: irq_cnt_next = {data_reg, irq_cnt_reg[7:0]};
                    default:    cmd_next = cmd_reg;
                endcase
            end
        end
        else if (mode_reg == MODE_TICK && irq_en_reg)
        begin
            if (irq_cnt_reg <= ticks_reg)
            begin
                irq_cnt_next = IRQ_RELOAD;
                irq_en_next  = 1'b0;
            end
            else
                irq_cnt_next = irq_cnt_reg - ticks_reg;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mode_reg  <= mode_t'(mode);
            addr_reg  <= address;
            data_reg  <= data;
            ticks_reg <= tick_count;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_vld_reg)
            res_reg <= res_next;
    end

    // mapper registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_mask_reg <= '1;
            chr_mask_reg <= '1;
            cmd_reg      <= CMD_CHR0;
            for (int i = 0; i < CHR_BANKS; i++)
                chr_bank_reg[i] <= '0;
            for (int i = 0; i < PRG_BANKS; i++)
                prg_bank_reg[i] <= '0;
            wram_sel_reg <= 1'b1;
            win_bank_reg <= '0;
            mirror_reg   <= MIRROR_VERTICAL;
            irq_en_reg   <= 1'b0;
            irq_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_PRG_MASK: prg_mask_reg <= cfg_data;
                    CFG_CHR_MASK: chr_mask_reg <= cfg_data;
                    default:      prg_mask_reg <= prg_mask_reg;
                endcase
            end
            if (advance && in_vld_reg)
            begin
                cmd_reg      <= cmd_next;
                chr_bank_reg <= chr_bank_next;
                prg_bank_reg <= prg_bank_next;
                wram_sel_reg <= wram_sel_next;
                win_bank_reg <= win_bank_next;
                mirror_reg   <= mirror_next;
                irq_en_reg   <= irq_en_next;
                irq_cnt_reg  <= irq_cnt_next;
            end
        end
    end

endmodule
